// ===== rtl/sollf_pkg.sv =====
// shared types, constants, microprogram and helpers for the lead-lag filter
package sollf_pkg;

    localparam int ACC_W = 64;

    typedef logic signed [ACC_W-1:0] t_acc;

    // largest magnitude every intermediate saturates to
    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN,
        CFG_NAT_FREQ,
        CFG_DAMPING,
        CFG_LEAD_FIRST,
        CFG_LEAD_SECOND,
        CFG_CYCLE_TIME,
        CFG_INIT_OUT,
        CFG_INIT_PREV
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [4:0] {
        SRC_ONE,
        SRC_W,
        SRC_T,
        SRC_TH,
        SRC_B1,
        SRC_B2,
        SRC_GAIN,
        SRC_U,
        SRC_U1,
        SRC_U2,
        SRC_V1,
        SRC_V2,
        SRC_S,
        SRC_A2,
        SRC_C1,
        SRC_C2,
        SRC_D1,
        SRC_D2,
        SRC_NUM
    } t_src;

    typedef enum logic [2:0] {
        DST_S,
        DST_A2,
        DST_C1,
        DST_C2,
        DST_D1,
        DST_D2,
        DST_NUM
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
    } t_uop;

    localparam int UOP_COUNT = 31;
    localparam int PC_W      = $clog2(UOP_COUNT);

    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_LAST = t_pc'(UOP_COUNT - 1);

    // one filter update, scratch value kept in s
    function automatic t_uop uop_rom(input t_pc pc);
        t_uop u;
        case (pc)
            0:       u = '{OP_DIV, SRC_ONE,  SRC_W,   DST_S};   // 1/w
            1:       u = '{OP_DIV, SRC_S,    SRC_W,   DST_A2};  // a2
            2:       u = '{OP_ADD, SRC_TH,   SRC_TH,  DST_S};
            3:       u = '{OP_DIV, SRC_S,    SRC_W,   DST_S};   // a1
            4:       u = '{OP_DIV, SRC_S,    SRC_T,   DST_C1};
            5:       u = '{OP_DIV, SRC_A2,   SRC_T,   DST_S};
            6:       u = '{OP_DIV, SRC_S,    SRC_T,   DST_C2};
            7:       u = '{OP_DIV, SRC_B1,   SRC_T,   DST_D1};
            8:       u = '{OP_DIV, SRC_B2,   SRC_T,   DST_S};
            9:       u = '{OP_DIV, SRC_S,    SRC_T,   DST_D2};
            10:      u = '{OP_ADD, SRC_C2,   SRC_C2,  DST_S};
            11:      u = '{OP_ADD, SRC_C1,   SRC_S,   DST_S};
            12:      u = '{OP_MUL, SRC_S,    SRC_V1,  DST_NUM};
            13:      u = '{OP_MUL, SRC_C2,   SRC_V2,  DST_S};
            14:      u = '{OP_SUB, SRC_NUM,  SRC_S,   DST_NUM};
            15:      u = '{OP_ADD, SRC_ONE,  SRC_D1,  DST_S};
            16:      u = '{OP_ADD, SRC_S,    SRC_D2,  DST_S};
            17:      u = '{OP_MUL, SRC_GAIN, SRC_S,   DST_S};
            18:      u = '{OP_MUL, SRC_S,    SRC_U,   DST_S};
            19:      u = '{OP_ADD, SRC_NUM,  SRC_S,   DST_NUM};
            20:      u = '{OP_ADD, SRC_D2,   SRC_D2,  DST_S};
            21:      u = '{OP_ADD, SRC_D1,   SRC_S,   DST_S};
            22:      u = '{OP_MUL, SRC_GAIN, SRC_S,   DST_S};
            23:      u = '{OP_MUL, SRC_S,    SRC_U1,  DST_S};
            24:      u = '{OP_SUB, SRC_NUM,  SRC_S,   DST_NUM};
            25:      u = '{OP_MUL, SRC_GAIN, SRC_D2,  DST_S};
            26:      u = '{OP_MUL, SRC_S,    SRC_U2,  DST_S};
            27:      u = '{OP_ADD, SRC_NUM,  SRC_S,   DST_NUM};
            28:      u = '{OP_ADD, SRC_ONE,  SRC_C1,  DST_S};
            29:      u = '{OP_ADD, SRC_S,    SRC_C2,  DST_S};   // denominator
            30:      u = '{OP_DIV, SRC_NUM,  SRC_S,   DST_S};   // new output
            default: u = '{OP_ADD, SRC_ONE,  SRC_ONE, DST_S};
        endcase
        return u;
    endfunction

    // magnitude of a signed value, the most negative one included
    function automatic logic [ACC_W-1:0] mag(input t_acc a);
        return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    endfunction

    // clamp a magnitude and apply the sign
    function automatic t_acc sat_mag(input logic neg, input logic ovf,
                                     input logic [ACC_W-1:0] m);
        logic [ACC_W-1:0] lim;
        lim = (ovf || m[ACC_W-1]) ? ACC_W'(ACC_MAX) : m;
        return neg ? -t_acc'(lim) : t_acc'(lim);
    endfunction

endpackage

// ===== rtl/sollf_mul.sv =====
// iterative fixed-point multiplier, one 32x32 partial product per cycle
module sollf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  sollf_pkg::t_acc i_a,
    input  sollf_pkg::t_acc i_b,
    output logic           o_done,
    output sollf_pkg::t_acc o_result
);
    import sollf_pkg::*;

    localparam int HALF_W = ACC_W / 2;
    localparam int PROD_W = 2 * ACC_W;

    logic [ACC_W-1:0]  r_xm;
    logic [ACC_W-1:0]  r_ym;
    logic              r_neg;
    logic [PROD_W-1:0] r_acc;
    logic [1:0]        r_step;
    logic              r_busy;
    logic              r_done;

    logic [HALF_W-1:0] x_half;
    logic [HALF_W-1:0] y_half;
    logic [ACC_W-1:0]  pp;
    logic [PROD_W-1:0] pp_sh;

    always_comb begin
        x_half = r_step[1] ? r_xm[ACC_W-1:HALF_W] : r_xm[HALF_W-1:0];
        y_half = r_step[0] ? r_ym[ACC_W-1:HALF_W] : r_ym[HALF_W-1:0];
        pp     = ACC_W'(x_half) * ACC_W'(y_half);
        case (r_step)
            2'd0:    pp_sh = PROD_W'(pp);
            2'd1:    pp_sh = PROD_W'(pp) << HALF_W;
            2'd2:    pp_sh = PROD_W'(pp) << HALF_W;
            default: pp_sh = PROD_W'(pp) << ACC_W;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xm  <= mag(i_a);
            r_ym  <= mag(i_b);
            r_neg <= i_a[ACC_W-1] ^ i_b[ACC_W-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
    end

    // drop the fraction bits, saturate what is left above
    assign o_result = sat_mag(r_neg, |r_acc[PROD_W-1:ACC_W+FRAC_BITS],
                              r_acc[ACC_W+FRAC_BITS-1:FRAC_BITS]);
    assign o_done   = r_done;

endmodule

// ===== rtl/sollf_div.sv =====
// restoring fixed-point divider, one quotient bit per cycle
module sollf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  sollf_pkg::t_acc i_a,
    input  sollf_pkg::t_acc i_b,
    output logic           o_done,
    output sollf_pkg::t_acc o_result
);
    import sollf_pkg::*;

    localparam int N     = ACC_W + FRAC_BITS;
    localparam int CNT_W = $clog2(N);

    logic [N-1:0]     r_num;
    logic [N-1:0]     r_quo;
    logic [ACC_W-1:0] r_den;
    logic [ACC_W-1:0] r_rem;
    logic             r_neg;
    logic             r_byzero;
    t_acc             r_zres;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [ACC_W:0]   rem_sh;
    logic [ACC_W:0]   diff;
    logic             qbit;

    always_comb begin
        rem_sh = {r_rem, r_num[N-1]};
        diff   = rem_sh - {1'b0, r_den};
        qbit   = !diff[ACC_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // zero divisor answers at once
                r_busy <= (i_b != '0);
                r_done <= (i_b == '0);
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num    <= {mag(i_a), {FRAC_BITS{1'b0}}};
            r_den    <= mag(i_b);
            r_rem    <= '0;
            r_quo    <= '0;
            r_neg    <= i_a[ACC_W-1] ^ i_b[ACC_W-1];
            r_byzero <= (i_b == '0);
            r_zres   <= (i_a == '0) ? '0 : (i_a[ACC_W-1] ? -ACC_MAX : ACC_MAX);
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= qbit ? diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
            r_quo <= {r_quo[N-2:0], qbit};
        end
    end

    assign o_result = r_byzero ? r_zres
                               : sat_mag(r_neg, |r_quo[N-1:ACC_W], r_quo[ACC_W-1:0]);
    assign o_done   = r_done;

endmodule

// ===== rtl/second_order_lead_lag_filter.sv =====
// top level of the second-order lead-lag filter with its microcoded sequencer
//
// items enter on the s_axis channel: tdata carries the sample, tuser carries
// enable (bit 0) and reset_request (bit 1). each item gives exactly one result
// on the m_axis channel: tdata holds output_value then cycle_count, tuser holds
// enable_out. coefficients come from the plain write port (i_cfg_we, i_cfg_addr,
// i_cfg_data); the user writes them only while idle, the block does not check.
// an enabled item without reset_request runs a 31-step microprogram on one
// shared adder, one iterative multiplier (4 steps) and one restoring divider
// (FRAC_BITS+64 steps, one quotient bit a cycle). the ten divisions dominate
// the time an item takes, and the next item is taken only once the result is
// handed to the output registers. a division by
// zero skips the quotient steps and finishes early, shortening the item.
// disabled or reset_request items need no arithmetic and go from idle
// straight to the finish step.
// tready is high only while the sequencer is idle.
// a result waits in the output registers while the receiver stalls; the next
// item is taken and computed meanwhile, and its state update waits until the
// output registers are free.
// reset (i_rst_n low at a clock edge) clears history, output and call counter
// and loads the default coefficients: gain, frequency, damping, cycle time 1.0
module second_order_lead_lag_filter #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_WRAP = 10000,
    localparam int CNT_W       = $clog2(COUNT_WRAP),
    localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_PAY_W   = DATA_WIDTH + CNT_W,
    localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]           i_s_axis_tdata,   // sample
    input  logic [1:0]                      i_s_axis_tuser,   // enable, reset_request
    // master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]          o_m_axis_tdata,   // output_value, cycle_count
    output logic [0:0]                      o_m_axis_tuser,   // enable_out
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sollf_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [DATA_WIDTH-1:0]           i_cfg_data
);
    import sollf_pkg::*;

    // wide enough for a written value and for the default of 1.0
    localparam int CFG_W = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 2;
    localparam logic signed [CFG_W-1:0] CFG_ONE = CFG_W'(1) << FRAC_BITS;
    localparam t_acc ACC_ONE = t_acc'(1) << FRAC_BITS;
    localparam logic signed [ACC_W:0] WIDE_MAX = (ACC_W + 1)'(ACC_MAX);
    localparam logic signed [ACC_W:0] WIDE_MIN = -WIDE_MAX;

    // coefficient registers
    logic signed [CFG_W-1:0]      r_gain;
    logic signed [CFG_W-1:0]      r_w;
    logic signed [CFG_W-1:0]      r_th;
    logic signed [CFG_W-1:0]      r_b1;
    logic signed [CFG_W-1:0]      r_b2;
    logic signed [CFG_W-1:0]      r_t;
    logic signed [CFG_W-1:0]      r_init_out;
    logic signed [CFG_W-1:0]      r_init_prev;

    // filter history and counter
    logic signed [DATA_WIDTH-1:0] r_cur;
    logic signed [DATA_WIDTH-1:0] r_od1;
    logic signed [DATA_WIDTH-1:0] r_od2;
    logic signed [DATA_WIDTH-1:0] r_iu1;
    logic signed [DATA_WIDTH-1:0] r_iu2;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_out_en;
    logic                         r_m_valid;

    // latched item
    logic signed [DATA_WIDTH-1:0] r_u;
    logic                         r_en;
    logic                         r_rst;

    // microprogram working registers
    t_acc r_s;
    t_acc r_a2;
    t_acc r_c1;
    t_acc r_c2;
    t_acc r_d1;
    t_acc r_d2;
    t_acc r_num;

    t_state r_state, n_state;
    t_pc    r_pc, n_pc;

    t_uop   uop;
    t_acc   opa;
    t_acc   opb;
    logic signed [ACC_W:0] alu_wide;
    t_acc   alu_res;
    logic   mul_start;
    logic   div_start;
    logic   mul_done;
    logic   div_done;
    t_acc   mul_res;
    t_acc   div_res;
    logic   wr_en;
    t_acc   wr_data;
    logic   s_accept;
    logic   out_free;
    logic   finish;
    logic signed [DATA_WIDTH-1:0] n_cur;

    function automatic t_acc src_val(input t_src sel);
        t_acc v;
        case (sel)
            SRC_ONE:  v = ACC_ONE;
            SRC_W:    v = t_acc'(r_w);
            SRC_T:    v = t_acc'(r_t);
            SRC_TH:   v = t_acc'(r_th);
            SRC_B1:   v = t_acc'(r_b1);
            SRC_B2:   v = t_acc'(r_b2);
            SRC_GAIN: v = t_acc'(r_gain);
            SRC_U:    v = t_acc'(r_u);
            SRC_U1:   v = t_acc'(r_iu1);
            SRC_U2:   v = t_acc'(r_iu2);
            SRC_V1:   v = t_acc'(r_od1);
            SRC_V2:   v = t_acc'(r_od2);
            SRC_S:    v = r_s;
            SRC_A2:   v = r_a2;
            SRC_C1:   v = r_c1;
            SRC_C2:   v = r_c2;
            SRC_D1:   v = r_d1;
            SRC_D2:   v = r_d2;
            SRC_NUM:  v = r_num;
            default:  v = '0;
        endcase
        return v;
    endfunction

    // clamp to the output range
    function automatic logic signed [DATA_WIDTH-1:0] sat_out(input t_acc v);
        logic fits;
        fits = (v[ACC_W-1:DATA_WIDTH-1] == '0) || (v[ACC_W-1:DATA_WIDTH-1] == '1);
        return fits ? v[DATA_WIDTH-1:0] : {v[ACC_W-1], {(DATA_WIDTH-1){~v[ACC_W-1]}}};
    endfunction

    sollf_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (opa),
        .i_b      (opb),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    sollf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_a      (opa),
        .i_b      (opb),
        .o_done   (div_done),
        .o_result (div_res)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_valid || i_m_axis_tready;
    assign finish          = (r_state == ST_FINISH) && out_free;

    // operand selection and the saturating adder
    always_comb begin
        uop = uop_rom(r_pc);
        opa = src_val(uop.src_a);
        opb = src_val(uop.src_b);
        if (uop.op == OP_SUB) begin
            alu_wide = (ACC_W + 1)'(opa) - (ACC_W + 1)'(opb);
        end else begin
            alu_wide = (ACC_W + 1)'(opa) + (ACC_W + 1)'(opb);
        end
        if (alu_wide > WIDE_MAX) begin
            alu_res = ACC_MAX;
        end else if (alu_wide < WIDE_MIN) begin
            alu_res = -ACC_MAX;
        end else begin
            alu_res = t_acc'(alu_wide);
        end
    end

    // sequencer
    always_comb begin
        logic step;
        step      = 1'b0;
        n_state   = r_state;
        n_pc      = r_pc;
        mul_start = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        wr_data   = alu_res;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_pc = '0;
                    // only an enabled item without reset_request needs arithmetic
                    n_state = (i_s_axis_tuser[0] && !i_s_axis_tuser[1]) ? ST_ISSUE
                                                                        : ST_FINISH;
                end
            end
            ST_ISSUE: begin
                case (uop.op)
                    OP_ADD, OP_SUB: begin
                        wr_en = 1'b1;
                        step  = 1'b1;
                    end
                    OP_MUL: begin
                        mul_start = 1'b1;
                        n_state   = ST_WAIT;
                    end
                    OP_DIV: begin
                        div_start = 1'b1;
                        n_state   = ST_WAIT;
                    end
                    default: ;
                endcase
            end
            ST_WAIT: begin
                if (uop.op == OP_MUL && mul_done) begin
                    wr_en   = 1'b1;
                    wr_data = mul_res;
                    step    = 1'b1;
                end else if (uop.op == OP_DIV && div_done) begin
                    wr_en   = 1'b1;
                    wr_data = div_res;
                    step    = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (step) begin
            n_pc    = r_pc + 1'b1;
            n_state = (r_pc == PC_LAST) ? ST_FINISH : ST_ISSUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // working register write-back
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (uop.dst)
                DST_S:   r_s   <= wr_data;
                DST_A2:  r_a2  <= wr_data;
                DST_C1:  r_c1  <= wr_data;
                DST_C2:  r_c2  <= wr_data;
                DST_D1:  r_d1  <= wr_data;
                DST_D2:  r_d2  <= wr_data;
                DST_NUM: r_num <= wr_data;
                default: ;
            endcase
        end
    end

    // latch the item fields
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_u   <= i_s_axis_tdata[DATA_WIDTH-1:0];
            r_en  <= i_s_axis_tuser[0];
            r_rst <= i_s_axis_tuser[1];
        end
    end

    // new output: hold when disabled, load on reset request, else the quotient
    always_comb begin
        if (!r_en) begin
            n_cur = r_cur;
        end else if (r_rst) begin
            n_cur = r_init_out[DATA_WIDTH-1:0];
        end else begin
            n_cur = sat_out(r_s);
        end
    end

    // history shift, counter and result, all when the output registers are free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_od1     <= '0;
            r_od2     <= '0;
            r_iu1     <= '0;
            r_iu2     <= '0;
            r_cnt     <= '0;
            r_out_en  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_cur     <= n_cur;
                r_od1     <= n_cur;
                r_od2     <= (r_en && r_rst) ? r_init_prev[DATA_WIDTH-1:0] : r_od1;
                r_iu1     <= r_u;
                r_iu2     <= r_iu1;
                r_cnt     <= (r_cnt == CNT_W'(COUNT_WRAP - 1)) ? '0 : r_cnt + 1'b1;
                r_out_en  <= r_en;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // coefficient writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= CFG_ONE;
            r_w         <= CFG_ONE;
            r_th        <= CFG_ONE;
            r_b1        <= '0;
            r_b2        <= '0;
            r_t         <= CFG_ONE;
            r_init_out  <= '0;
            r_init_prev <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_GAIN:        r_gain      <= CFG_W'($signed(i_cfg_data));
                CFG_NAT_FREQ:    r_w         <= CFG_W'(i_cfg_data[DATA_WIDTH-2:0]);
                CFG_DAMPING:     r_th        <= CFG_W'($signed(i_cfg_data));
                CFG_LEAD_FIRST:  r_b1        <= CFG_W'($signed(i_cfg_data));
                CFG_LEAD_SECOND: r_b2        <= CFG_W'($signed(i_cfg_data));
                CFG_CYCLE_TIME:  r_t         <= CFG_W'(i_cfg_data[DATA_WIDTH-2:0]);
                CFG_INIT_OUT:    r_init_out  <= CFG_W'($signed(i_cfg_data));
                CFG_INIT_PREV:   r_init_prev <= CFG_W'($signed(i_cfg_data));
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid   = r_m_valid;
    assign o_m_axis_tdata    = OUT_TDATA_W'({r_cnt, r_cur});
    assign o_m_axis_tuser[0] = r_out_en;

    // an accepted item always leaves idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != ST_IDLE))
        else $error("item accepted but sequencer stayed idle");

    // a finished item shows up as a valid result
    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_m_axis_tvalid)
        else $error("finished item produced no result");

    // arithmetic units report only while the sequencer waits on them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_done || div_done) |-> (r_state == ST_WAIT))
        else $error("unit finished outside of a wait step");

    // waiting on the multiplier, the divider stays quiet
    a_wait_unit_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT && uop.op == OP_MUL) |-> !div_done)
        else $error("divider finished while multiplier step pending");

    // call counter stays below the wrap value
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_cnt <= CNT_W'(COUNT_WRAP - 1)))
        else $error("call counter out of range");

endmodule
